>>> design/cbpb_pkg.sv
`timescale 1ns / 1ps
package cbpb_pkg;

  // Default coordinate width (signed Q15.16)
  localparam int COORD_WIDTH_DEF = 32;

  // Curve parameter t is unsigned Q1.30
  localparam int T_BITS = 30;
  localparam int MUL_W  = 31;
  localparam int NUM_W  = 34;
  localparam logic [63:0] COEF_LIMIT = 64'd1 << T_BITS;
  localparam logic [63:0] T_MASK     = (64'd1 << T_BITS) - 64'd1;
  localparam logic [63:0] SQRT_TOP   = 64'd1 << 62;

  // Segment kinds
  localparam logic [1:0] MODE_MOVE  = 2'd0;
  localparam logic [1:0] MODE_CURVE = 2'd1;

  // de Casteljau on a four-entry shift line: bit i set means step i is a lerp,
  // clear means a plain rotate
  localparam int CJ_STEPS = 9;
  localparam logic [CJ_STEPS-1:0] CJ_LERP = 9'b100110111;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_COEF, S_NORM, S_BRANCH, S_BB, S_DISC, S_DCHK,
    S_SQRT_INIT, S_SQRT, S_ROOT, S_RCHK, S_DIV, S_CJ_LOAD, S_CJ_HI, S_CJ_LO,
    S_CJ_GROW, S_ROOT_NEXT, S_AXIS_END, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_COEF, OP_NORM, OP_BB, OP_DISC, OP_SQRT_INIT,
    OP_SQRT, OP_ROOT, OP_DIV_INIT, OP_DIV, OP_CJ_LOAD, OP_CJ_HI, OP_CJ_LO,
    OP_GROW, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    ROOT_PLUS, ROOT_MINUS, ROOT_LIN
  } root_t;

  typedef struct packed {
    op_t   op;
    logic  axis;
    logic  coord;
    root_t root;
  } cmd_t;

  typedef struct packed {
    logic curve;
    logic last;
    logic norm_done;
    logic a_zero;
    logic b_zero;
    logic disc_neg;
    logic sqrt_last;
    logic root_ok;
    logic div_last;
    logic cj_last;
    logic out_free;
  } status_t;

endpackage

>>> design/cbpb_seg_if.sv
`timescale 1ns / 1ps
interface cbpb_seg_if #(
  parameter int COORD_WIDTH = cbpb_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic signed [COORD_WIDTH-1:0] ctrl1_x;
  logic signed [COORD_WIDTH-1:0] ctrl1_y;
  logic signed [COORD_WIDTH-1:0] ctrl2_x;
  logic signed [COORD_WIDTH-1:0] ctrl2_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic                          last_segment;

  modport source (
    output valid, mode, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, last_segment,
    input  ready
  );
  modport sink (
    input  valid, mode, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, last_segment,
    output ready
  );
endinterface

>>> design/cbpb_box_if.sv
`timescale 1ns / 1ps
interface cbpb_box_if #(
  parameter int COORD_WIDTH = cbpb_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_x;
  logic signed [COORD_WIDTH-1:0] box_y;
  logic [COORD_WIDTH-2:0]        box_width;
  logic [COORD_WIDTH-2:0]        box_height;

  modport source (
    output valid, box_x, box_y, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, box_x, box_y, box_width, box_height,
    output ready
  );
endinterface

>>> design/cubic_bezier_path_bbox_core.sv
`timescale 1ns / 1ps
// Channel  Modport        Beat
// seg      cbpb_seg_if    mode, control points, end point, last_segment
// bbox     cbpb_box_if    box_x, box_y, box_width, box_height (last segment only)
//
// Move and other segments go straight to the finish. A curve runs both axes on one
// shared 31x31 multiplier, a 32-step square root and a 30-step divider, after
// normalizing shifts of the coefficients.
// The output register lets the next segment enter while a box beat waits.
// Reset (rst, synchronous) clears the current point and the box.
module cubic_bezier_path_bbox_core #(
  parameter int COORD_WIDTH = cbpb_pkg::COORD_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  cbpb_seg_if.sink    seg,
  cbpb_box_if.source  bbox
);
  import cbpb_pkg::*;

  cmd_t    cmd;
  status_t status;

  cbpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (seg.valid),
    .in_ready (seg.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cbpb_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .mode         (seg.mode),
    .ctrl1_x      (seg.ctrl1_x),
    .ctrl1_y      (seg.ctrl1_y),
    .ctrl2_x      (seg.ctrl2_x),
    .ctrl2_y      (seg.ctrl2_y),
    .end_x        (seg.end_x),
    .end_y        (seg.end_y),
    .last_segment (seg.last_segment),
    .out_valid    (bbox.valid),
    .out_ready    (bbox.ready),
    .box_x        (bbox.box_x),
    .box_y        (bbox.box_y),
    .box_width    (bbox.box_width),
    .box_height   (bbox.box_height)
  );

endmodule

>>> design/cbpb_datapath.sv
`timescale 1ns / 1ps
module cbpb_datapath #(
  parameter int COORD_WIDTH = cbpb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cbpb_pkg::cmd_t                cmd,
  output cbpb_pkg::status_t             status,
  input  logic [1:0]                    mode,
  input  logic signed [COORD_WIDTH-1:0] ctrl1_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl1_y,
  input  logic signed [COORD_WIDTH-1:0] ctrl2_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl2_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic                          last_segment,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] box_x,
  output logic signed [COORD_WIDTH-1:0] box_y,
  output logic [COORD_WIDTH-2:0]        box_width,
  output logic [COORD_WIDTH-2:0]        box_height
);
  import cbpb_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int CFW = CW + 4;

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] p,
                                                input logic signed [CW-1:0] q);
    return (q < p) ? q : p;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] p,
                                                input logic signed [CW-1:0] q);
    return (q > p) ? q : p;
  endfunction

  function automatic logic [CFW-1:0] mag_cf(input logic signed [CFW-1:0] v);
    return v[CFW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // magnitude halved, sign kept (truncation toward zero)
  function automatic logic signed [CFW-1:0] half_cf(input logic signed [CFW-1:0] v);
    logic [CFW-1:0] m;
    m = mag_cf(v) >> 1;
    return v[CFW-1] ? -$signed(m) : $signed(m);
  endfunction

  // path state
  logic signed [CW-1:0] cur_x, cur_y, lo_x, lo_y, hi_x, hi_y;
  logic                 started;
  logic                 is_curve, is_last;

  // segment control points
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];

  // derivative coefficients, discriminant, root search
  logic signed [CFW-1:0]   ca, cb, cc;
  logic [63:0]             bb;
  logic signed [63:0]      disc;
  logic [63:0]             sv, sr, sbit;
  logic [4:0]              scnt;
  logic signed [NUM_W-1:0] num, den;
  logic [32:0]             rem;
  logic [T_BITS:0]         tq;
  logic                    div_one;
  logic [4:0]              dcnt;

  // de Casteljau shift line
  logic signed [CW-1:0]    q [4];
  logic [3:0]              cstep;
  logic [2*MUL_W-1:0]      acc;

  // accept: seed, then grow by the end point (move, curve) and start point (curve)
  logic signed [CW-1:0] lx0, hx0, ly0, hy0, lx1, hx1, ly1, hy1;
  always_comb begin
    lx0 = started ? lo_x : end_x;
    hx0 = started ? hi_x : end_x;
    ly0 = started ? lo_y : end_y;
    hy0 = started ? hi_y : end_y;
    lx1 = lx0;
    hx1 = hx0;
    ly1 = ly0;
    hy1 = hy0;
    if (mode inside {MODE_MOVE, MODE_CURVE}) begin
      lx1 = smin(lx1, end_x);
      hx1 = smax(hx1, end_x);
      ly1 = smin(ly1, end_y);
      hy1 = smax(hy1, end_y);
    end
    if (mode == MODE_CURVE) begin
      lx1 = smin(lx1, cur_x);
      hx1 = smax(hx1, cur_x);
      ly1 = smin(ly1, cur_y);
      hy1 = smax(hy1, cur_y);
    end
  end

  // coefficients of the derivative for the selected axis
  logic signed [CFW-1:0] e0, e1, e2, e3, a_new, b_new, c_new;
  always_comb begin
    e0 = cmd.axis ? CFW'(py[0]) : CFW'(px[0]);
    e1 = cmd.axis ? CFW'(py[1]) : CFW'(px[1]);
    e2 = cmd.axis ? CFW'(py[2]) : CFW'(px[2]);
    e3 = cmd.axis ? CFW'(py[3]) : CFW'(px[3]);
    a_new = e0 - e1 - (e1 <<< 1) + e2 + (e2 <<< 1) - e3;
    b_new = ((e1 <<< 1) - e0 - e2) <<< 1;
    c_new = e0 - e1;
  end

  logic [CFW-1:0] ma, mb, mc;
  logic           norm_done;
  assign ma = mag_cf(ca);
  assign mb = mag_cf(cb);
  assign mc = mag_cf(cc);
  assign norm_done = (64'(ma) < COEF_LIMIT) && (64'(mb) < COEF_LIMIT) &&
                     (64'(mc) < COEF_LIMIT);

  // lerp of the two front taps
  logic signed [CW:0]   ld;
  logic [CW:0]          lm;
  logic [63:0]          lm64;
  logic [MUL_W-1:0]     m_hi, m_lo;
  always_comb begin
    ld   = {q[1][CW-1], q[1]} - {q[0][CW-1], q[0]};
    lm   = ld[CW] ? $unsigned(-ld) : $unsigned(ld);
    lm64 = 64'(lm);
    m_hi = MUL_W'(lm64 >> T_BITS);
    m_lo = MUL_W'(lm64 & T_MASK);
  end

  // shared multiplier
  logic [MUL_W-1:0]   mul_x, mul_y;
  logic [2*MUL_W-1:0] prod;
  always_comb begin
    case (cmd.op)
      OP_BB: begin
        mul_x = MUL_W'(mb);
        mul_y = MUL_W'(mb);
      end
      OP_DISC: begin
        mul_x = MUL_W'(ma);
        mul_y = MUL_W'(mc);
      end
      OP_CJ_HI: begin
        mul_x = m_hi;
        mul_y = tq;
      end
      OP_CJ_LO: begin
        mul_x = m_lo;
        mul_y = tq;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  logic [63:0]        ac4;
  logic signed [63:0] disc_new;
  assign ac4      = 64'(prod) << 2;
  assign disc_new = (ca[CFW-1] ^ cc[CFW-1]) ? $signed(bb + ac4) : $signed(bb - ac4);

  // square root step
  logic [63:0] trial;
  assign trial = sr + sbit;

  // root candidate
  logic signed [NUM_W-1:0] nb, nc, na2, ns, num_raw, den_raw;
  always_comb begin
    nb  = NUM_W'(cb);
    nc  = NUM_W'(cc);
    na2 = NUM_W'(ca) <<< 1;
    ns  = $signed({2'b00, sr[31:0]});
    case (cmd.root)
      ROOT_PLUS: begin
        num_raw = ns - nb;
        den_raw = na2;
      end
      ROOT_MINUS: begin
        num_raw = -nb - ns;
        den_raw = na2;
      end
      default: begin
        num_raw = -nc;
        den_raw = nb;
      end
    endcase
  end

  // division step
  logic [32:0] r2, den_u;
  logic        r_ge;
  assign r2    = {rem[31:0], 1'b0};
  assign den_u = 33'(den);
  assign r_ge  = r2 >= den_u;

  // lerp result
  logic [2*MUL_W-1:0]   lsum;
  logic [CW:0]          ls;
  logic signed [CW+1:0] lw;
  always_comb begin
    lsum = acc + (prod >> T_BITS);
    ls   = (CW+1)'(lsum);
    lw   = ld[CW] ? ((CW+2)'(q[0]) - $signed({1'b0, ls}))
                  : ((CW+2)'(q[0]) + $signed({1'b0, ls}));
  end

  // box size, saturated
  logic signed [CW:0] wd, ht;
  logic [CW-2:0]      w_sat, h_sat;
  always_comb begin
    wd    = {hi_x[CW-1], hi_x} - {lo_x[CW-1], lo_x};
    ht    = {hi_y[CW-1], hi_y} - {lo_y[CW-1], lo_y};
    w_sat = (wd[CW] | wd[CW-1]) ? '1 : wd[CW-2:0];
    h_sat = (ht[CW] | ht[CW-1]) ? '1 : ht[CW-2:0];
  end

  // path state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x   <= '0;
      cur_y   <= '0;
      lo_x    <= '0;
      lo_y    <= '0;
      hi_x    <= '0;
      hi_y    <= '0;
      started <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          lo_x    <= lx1;
          hi_x    <= hx1;
          lo_y    <= ly1;
          hi_y    <= hy1;
          started <= 1'b1;
          cur_x   <= end_x;
          cur_y   <= end_y;
        end
        OP_GROW: begin
          if (cmd.coord) begin
            lo_y <= smin(lo_y, q[3]);
            hi_y <= smax(hi_y, q[3]);
          end else begin
            lo_x <= smin(lo_x, q[3]);
            hi_x <= smax(hi_x, q[3]);
          end
        end
        OP_EMIT: begin
          lo_x    <= '0;
          lo_y    <= '0;
          hi_x    <= '0;
          hi_y    <= '0;
          started <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        is_curve <= (mode == MODE_CURVE);
        is_last  <= last_segment;
        px[0] <= cur_x;
        py[0] <= cur_y;
        px[1] <= ctrl1_x;
        py[1] <= ctrl1_y;
        px[2] <= ctrl2_x;
        py[2] <= ctrl2_y;
        px[3] <= end_x;
        py[3] <= end_y;
      end
      OP_COEF: begin
        ca <= a_new;
        cb <= b_new;
        cc <= c_new;
      end
      OP_NORM: begin
        if (!norm_done) begin
          ca <= half_cf(ca);
          cb <= half_cf(cb);
          cc <= half_cf(cc);
        end
      end
      OP_BB:   bb   <= 64'(prod);
      OP_DISC: disc <= disc_new;
      OP_SQRT_INIT: begin
        sv   <= $unsigned(disc);
        sr   <= '0;
        sbit <= SQRT_TOP;
        scnt <= '0;
      end
      OP_SQRT: begin
        if (sv >= trial) begin
          sv <= sv - trial;
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
        scnt <= scnt + 5'd1;
      end
      OP_ROOT: begin
        if (den_raw[NUM_W-1]) begin
          num <= -num_raw;
          den <= -den_raw;
        end else begin
          num <= num_raw;
          den <= den_raw;
        end
      end
      OP_DIV_INIT: begin
        div_one <= (num == den);
        rem     <= 33'(num);
        tq      <= (num == den) ? (T_BITS+1)'(COEF_LIMIT) : '0;
        dcnt    <= '0;
      end
      OP_DIV: begin
        if (!div_one) begin
          rem  <= r_ge ? (r2 - den_u) : r2;
          tq   <= {tq[T_BITS-1:0], r_ge};
          dcnt <= dcnt + 5'd1;
        end
      end
      OP_CJ_LOAD: begin
        q[0]  <= cmd.coord ? py[0] : px[0];
        q[1]  <= cmd.coord ? py[1] : px[1];
        q[2]  <= cmd.coord ? py[2] : px[2];
        q[3]  <= cmd.coord ? py[3] : px[3];
        cstep <= '0;
      end
      OP_CJ_HI: acc <= prod;
      OP_CJ_LO: begin
        q[0]  <= q[1];
        q[1]  <= q[2];
        q[2]  <= q[3];
        q[3]  <= CJ_LERP[cstep] ? CW'(lw) : q[0];
        cstep <= cstep + 4'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      box_x      <= lo_x;
      box_y      <= lo_y;
      box_width  <= w_sat;
      box_height <= h_sat;
    end
  end

  // status to the controller
  always_comb begin
    status.curve     = is_curve;
    status.last      = is_last;
    status.norm_done = norm_done;
    status.a_zero    = (ca == '0);
    status.b_zero    = (cb == '0);
    status.disc_neg  = disc[63];
    status.sqrt_last = (scnt == 5'd31);
    status.root_ok   = (den != '0) && !num[NUM_W-1] && (num <= den);
    status.div_last  = div_one || (dcnt == 5'(T_BITS-1));
    status.cj_last   = (cstep == 4'(CJ_STEPS-1));
    status.out_free  = !out_valid || out_ready;
  end

endmodule

>>> design/cbpb_ctrl.sv
`timescale 1ns / 1ps
module cbpb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cbpb_pkg::status_t status,
  output cbpb_pkg::cmd_t    cmd
);
  import cbpb_pkg::*;

  state_t state, state_next;
  logic   axis, axis_next;
  logic   coord, coord_next;
  root_t  root, root_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
      coord <= 1'b0;
      root  <= ROOT_PLUS;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      coord <= coord_next;
      root  <= root_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    coord_next = coord;
    root_next  = root;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        axis_next  = 1'b0;
        state_next = status.curve ? S_COEF : S_FINISH;
      end
      S_COEF:   state_next = S_NORM;
      S_NORM:   if (status.norm_done) state_next = S_BRANCH;
      S_BRANCH: begin
        if (!status.a_zero) begin
          state_next = S_BB;
        end else if (status.b_zero) begin
          state_next = S_AXIS_END;
        end else begin
          root_next  = ROOT_LIN;
          state_next = S_ROOT;
        end
      end
      S_BB:        state_next = S_DISC;
      S_DISC:      state_next = S_DCHK;
      S_DCHK:      state_next = status.disc_neg ? S_AXIS_END : S_SQRT_INIT;
      S_SQRT_INIT: state_next = S_SQRT;
      S_SQRT: begin
        if (status.sqrt_last) begin
          root_next  = ROOT_PLUS;
          state_next = S_ROOT;
        end
      end
      S_ROOT:      state_next = S_RCHK;
      S_RCHK:      state_next = status.root_ok ? S_DIV : S_ROOT_NEXT;
      S_DIV: begin
        if (status.div_last) begin
          coord_next = 1'b0;
          state_next = S_CJ_LOAD;
        end
      end
      S_CJ_LOAD:   state_next = S_CJ_HI;
      S_CJ_HI:     state_next = S_CJ_LO;
      S_CJ_LO:     state_next = status.cj_last ? S_CJ_GROW : S_CJ_HI;
      S_CJ_GROW: begin
        if (!coord) begin
          coord_next = 1'b1;
          state_next = S_CJ_LOAD;
        end else begin
          state_next = S_ROOT_NEXT;
        end
      end
      S_ROOT_NEXT: begin
        if (root == ROOT_PLUS) begin
          root_next  = ROOT_MINUS;
          state_next = S_ROOT;
        end else begin
          state_next = S_AXIS_END;
        end
      end
      S_AXIS_END: begin
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_COEF;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.last || status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready  = (state == S_IDLE);
    cmd.op    = OP_NONE;
    cmd.axis  = axis;
    cmd.coord = coord;
    cmd.root  = root;
    case (state)
      S_IDLE:      if (in_valid) cmd.op = OP_ACCEPT;
      S_COEF:      cmd.op = OP_COEF;
      S_NORM:      cmd.op = OP_NORM;
      S_BB:        cmd.op = OP_BB;
      S_DISC:      cmd.op = OP_DISC;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT;
      S_ROOT:      cmd.op = OP_ROOT;
      S_RCHK:      if (status.root_ok) cmd.op = OP_DIV_INIT;
      S_DIV:       cmd.op = OP_DIV;
      S_CJ_LOAD:   cmd.op = OP_CJ_LOAD;
      S_CJ_HI:     cmd.op = OP_CJ_HI;
      S_CJ_LO:     cmd.op = OP_CJ_LO;
      S_CJ_GROW:   cmd.op = OP_GROW;
      S_FINISH:    if (status.last && status.out_free) cmd.op = OP_EMIT;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> design/cbpb_checker.sv
`timescale 1ns / 1ps
module cbpb_checker (
  input logic clk,
  input logic rst,
  input logic seg_valid,
  input logic seg_ready,
  input logic bbox_valid,
  input logic bbox_ready
);

  // a box beat waits until taken
  assert property (@(posedge clk) disable iff (rst)
    bbox_valid && !bbox_ready |=> bbox_valid)
    else $error("box beat dropped before taken");

  // nothing pending right after reset
  assert property (@(posedge clk) rst |=> !bbox_valid)
    else $error("box valid after reset");

  // one segment in work at a time
  assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_ready |=> !seg_ready)
    else $error("segment taken while busy");

  // a new box only comes out of a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(bbox_valid) |-> !$past(seg_ready))
    else $error("box appeared without a segment in work");

endmodule

bind cubic_bezier_path_bbox_core cbpb_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .seg_valid  (seg.valid),
  .seg_ready  (seg.ready),
  .bbox_valid (bbox.valid),
  .bbox_ready (bbox.ready)
);
